>>> hw/rtl/pss_pkg.sv
package pss_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_FRONT     = 3'd0,
        OP_ADD_REAR      = 3'd1,
        OP_REMOVE_FRONT  = 3'd2,
        OP_REMOVE_REAR   = 3'd3,
        OP_REMOVE_AT     = 3'd4,
        OP_INSERT_BEFORE = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CAPTURE,
        S_TEST,
        S_READ,
        S_WRITE,
        S_PUT,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/pss_mem.sv
module pss_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/positional_sequence_store_unit.sv
// Bounded ordered sequence (front at position 1) kept in a single-port-write,
// registered-read RAM. Elements are moved one at a time through that RAM port
// by a small sequencer, so a request takes a number of cycles set by how many
// elements must shift. The result is registered as the sequencer returns to
// idle, where it can take the next request. A new request is taken only
// while the sequencer is idle. A finished result sits in an output register
// and the next request may start while it waits. A second finished result
// holds the sequencer until that register frees up. Unused opcodes answer ok
// with no change.
module positional_sequence_store_unit import pss_pkg::*; #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VALUE_W-1:0]  o_removed_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int EW  = ELEMENT_WIDTH;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_add, n_add;
    logic [EW-1:0]   r_val, n_val;
    logic [EW-1:0]   r_removed, n_removed;
    t_status         r_status, n_status;

    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_out_removed, n_out_removed;
    t_status             r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic            mem_wr_en;
    logic [CW-1:0]   mem_wr_ptr;
    logic [EW-1:0]   mem_wr_data;
    logic [CW-1:0]   mem_rd_ptr;
    logic [EW-1:0]   mem_rd_data;

    pss_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_ptr[AW-1:0]),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_ptr[AW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ptr         <= n_ptr;
        r_idx         <= n_idx;
        r_add         <= n_add;
        r_val         <= n_val;
        r_removed     <= n_removed;
        r_status      <= n_status;
        r_out_removed <= n_out_removed;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
    end

    always_comb begin
        logic [PW-1:0] pos_w;
        logic [PW-1:0] cnt_w;
        logic          full;
        logic          empty;
        logic          go;
        logic          out_free;

        pos_w    = PW'(i_position);
        cnt_w    = PW'(r_count);
        full     = (r_count == CW'(CAPACITY));
        empty    = (r_count == '0);
        go       = 1'b0;
        out_free = !r_out_valid || !i_out_stall;

        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_idx         = r_idx;
        n_add         = r_add;
        n_val         = r_val;
        n_removed     = r_removed;
        n_status      = r_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_removed = r_out_removed;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;

        mem_wr_en   = 1'b0;
        mem_wr_ptr  = r_ptr;
        mem_wr_data = mem_rd_data;
        mem_rd_ptr  = r_ptr;

        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val     = EW'(i_value);
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_add     = 1'b1;
                    n_idx     = '0;
                    case (t_opcode'(i_opcode))
                        OP_ADD_FRONT: begin
                            if (full) n_status = ST_FULL;
                            else go = 1'b1;
                        end
                        OP_ADD_REAR: begin
                            n_idx = r_count;
                            if (full) n_status = ST_FULL;
                            else go = 1'b1;
                        end
                        OP_REMOVE_FRONT: begin
                            n_add = 1'b0;
                            if (empty) n_status = ST_UNDERFLOW;
                            else go = 1'b1;
                        end
                        OP_REMOVE_REAR: begin
                            n_add = 1'b0;
                            n_idx = r_count - CW'(1);
                            if (empty) n_status = ST_UNDERFLOW;
                            else go = 1'b1;
                        end
                        OP_REMOVE_AT: begin
                            n_add = 1'b0;
                            n_idx = CW'(pos_w - PW'(1));
                            if (pos_w == '0 || pos_w > cnt_w) n_status = ST_RANGE;
                            else go = 1'b1;
                        end
                        OP_INSERT_BEFORE: begin
                            n_idx = CW'(pos_w - PW'(1));
                            if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                go = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (!go) begin
                        n_state = S_DONE;
                    end else if (n_add) begin
                        n_ptr   = r_count;
                        n_state = S_TEST;
                    end else begin
                        n_ptr   = n_idx;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                mem_rd_ptr = r_idx;
                n_state    = S_CAPTURE;
            end
            S_CAPTURE: begin
                n_removed = mem_rd_data;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (r_add) begin
                    n_state = (r_ptr > r_idx) ? S_READ : S_PUT;
                end else if (CW'(r_ptr + CW'(1)) < r_count) begin
                    n_state = S_READ;
                end else begin
                    // last element closed up: drop the count
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                mem_rd_ptr = r_add ? r_ptr - CW'(1) : r_ptr + CW'(1);
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                mem_wr_en   = 1'b1;
                mem_wr_ptr  = r_ptr;
                mem_wr_data = mem_rd_data;
                n_ptr       = r_add ? r_ptr - CW'(1) : r_ptr + CW'(1);
                n_state     = S_TEST;
            end
            S_PUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_ptr  = r_idx;
                mem_wr_data = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_removed = VALUE_W'(r_removed);
                    n_out_status  = r_status;
                    n_out_count   = COUNT_W'(r_count);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_status        = r_out_status;
    assign o_count         = r_out_count;

endmodule

>>> tb/sv/tb_positional_sequence_store_unit.sv
module tb_positional_sequence_store_unit;
    import pss_pkg::*;

    localparam int SEQ_CAPACITY = 16;
    localparam int RANDOM_REQUESTS = 850;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [OPCODE_W-1:0] OPC_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OPC_SPARE_7 = 3'd7;

    typedef struct {
        logic [VALUE_W-1:0] removed;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_seq_result;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
        bit                  typed;
        t_seq_result         expected;
    } t_req_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OPCODE_W-1:0] i_opcode;
    logic [POS_W-1:0]    i_position;
    logic [VALUE_W-1:0]  i_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [VALUE_W-1:0]  o_removed_value;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count;

    logic [VALUE_W-1:0] seq_model [SEQ_CAPACITY];
    int                 model_len;
    int                 deepest_len;
    t_seq_result        pending_results [$];
    t_req_row           directed_rows [$];

    int requests_sent;
    int results_checked;
    int mismatches;
    int status_seen [4];
    int burst_left;
    bit hold_done;

    positional_sequence_store_unit #(
        .CAPACITY     (SEQ_CAPACITY),
        .ELEMENT_WIDTH(VALUE_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_count        (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #7200000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    // Shift later elements back and place v at 0-based slot idx.
    task automatic open_at(input int idx, input logic [VALUE_W-1:0] v);
        int k;
        for (k = model_len; k > idx; k--) seq_model[k] = seq_model[k-1];
        seq_model[idx] = v;
        model_len++;
        if (model_len > deepest_len) deepest_len = model_len;
    endtask

    // Take out 0-based slot idx and close the gap.
    task automatic close_at(input int idx, output logic [VALUE_W-1:0] v);
        int k;
        v = seq_model[idx];
        for (k = idx; k + 1 < model_len; k++) seq_model[k] = seq_model[k+1];
        model_len--;
    endtask

    task automatic step_sequence_model(input logic [OPCODE_W-1:0] op,
                                       input logic [POS_W-1:0] pos,
                                       input logic [VALUE_W-1:0] val,
                                       output t_seq_result res);
        bit is_full;
        int p;
        is_full = (model_len >= SEQ_CAPACITY);
        p = int'(pos);
        res.removed = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD_FRONT: begin
                if (is_full) res.status = ST_FULL;
                else open_at(0, val);
            end
            OP_ADD_REAR: begin
                if (is_full) res.status = ST_FULL;
                else open_at(model_len, val);
            end
            OP_REMOVE_FRONT: begin
                if (model_len == 0) res.status = ST_UNDERFLOW;
                else close_at(0, res.removed);
            end
            OP_REMOVE_REAR: begin
                if (model_len == 0) res.status = ST_UNDERFLOW;
                else close_at(model_len - 1, res.removed);
            end
            OP_REMOVE_AT: begin
                if (p < 1 || p > model_len) res.status = ST_RANGE;
                else close_at(p - 1, res.removed);
            end
            OP_INSERT_BEFORE: begin
                // range check wins over the full check
                if (p < 1 || p > model_len + 1) res.status = ST_RANGE;
                else if (is_full) res.status = ST_FULL;
                else open_at(p - 1, val);
            end
            default: ;
        endcase
        res.count = COUNT_W'(model_len);
    endtask

    function automatic t_req_row plain_row(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic [VALUE_W-1:0] val);
        t_req_row r;
        r.opcode = op;
        r.position = pos;
        r.value = val;
        r.typed = 1'b0;
        r.expected.removed = '0;
        r.expected.status = ST_OK;
        r.expected.count = '0;
        return r;
    endfunction

    function automatic t_req_row known_row(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic [VALUE_W-1:0] val, t_status st,
                                           logic [COUNT_W-1:0] cnt);
        t_req_row r;
        r = plain_row(op, pos, val);
        r.typed = 1'b1;
        r.expected.status = st;
        r.expected.count = cnt;
        return r;
    endfunction

    // Offer one request, hold it until taken, then pace the sender in bursts.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val, input bit typed,
                                input t_seq_result typed_result);
        t_seq_result predicted;
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_position <= pos;
        i_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        step_sequence_model(op, pos, val, predicted);
        pending_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(7) == 0) repeat ($urandom_range(30, 8)) @(posedge i_clk);
            else repeat ($urandom_range(3, 1)) @(posedge i_clk);
            if ($urandom_range(5) == 0) burst_left = $urandom_range(80, 30);
            else burst_left = $urandom_range(12, 1);
        end
    endtask

    // Receiver: random stall phases, plus one long hold-off to back up the block.
    initial begin
        int phase_len;
        int stall_pct;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            phase_len = $urandom_range(60, 5);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (phase_len) begin
                @(posedge i_clk);
                if (!hold_done && results_checked >= 250) begin
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_seq_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: removed %h status %0d count %0d",
                             o_removed_value, o_status, o_count);
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                status_seen[exp_res.status]++;
                if (o_removed_value !== exp_res.removed || o_status !== exp_res.status ||
                    o_count !== exp_res.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 results_checked, exp_res.removed, exp_res.status,
                                 exp_res.count, o_removed_value, o_status, o_count);
                end
            end
        end
    end

    initial begin
        t_req_row row;
        t_seq_result no_result;
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [VALUE_W-1:0] val;
        int n;
        int pick;
        int top;
        bit grow;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode <= '0;
        i_position <= '0;
        i_value <= '0;
        model_len = 0;
        deepest_len = 0;
        burst_left = 4;
        grow = 1'b1;
        row = plain_row(OP_ADD_FRONT, '0, '0);
        no_result = row.expected;

        // empty store errors
        directed_rows.push_back(known_row(OP_REMOVE_FRONT, 5'd0, '0, ST_UNDERFLOW, 5'd0));
        directed_rows.push_back(known_row(OP_REMOVE_REAR, 5'd31, '1, ST_UNDERFLOW, 5'd0));
        directed_rows.push_back(known_row(OP_REMOVE_AT, 5'd1, '0, ST_RANGE, 5'd0));
        directed_rows.push_back(known_row(OP_INSERT_BEFORE, 5'd2, 32'd5, ST_RANGE, 5'd0));
        // fill to capacity through every add form
        directed_rows.push_back(known_row(OP_INSERT_BEFORE, 5'd1, '1, ST_OK, 5'd1));
        directed_rows.push_back(known_row(OP_ADD_FRONT, 5'd0, '0, ST_OK, 5'd2));
        directed_rows.push_back(plain_row(OP_ADD_REAR, 5'd0, 32'h0000_0001));
        directed_rows.push_back(plain_row(OP_INSERT_BEFORE, 5'd2, 32'h8000_0000));
        directed_rows.push_back(plain_row(OP_INSERT_BEFORE, 5'd5, 32'h1234_5678));
        directed_rows.push_back(plain_row(OP_ADD_FRONT, 5'd0, 32'hdead_beef));
        directed_rows.push_back(plain_row(OP_ADD_REAR, 5'd0, 32'h7fff_ffff));
        directed_rows.push_back(plain_row(OP_INSERT_BEFORE, 5'd4, 32'h0f0f_0f0f));
        directed_rows.push_back(plain_row(OP_ADD_FRONT, 5'd0, 32'hc3c3_3c3c));
        directed_rows.push_back(plain_row(OP_ADD_REAR, 5'd0, 32'h0000_0100));
        directed_rows.push_back(plain_row(OP_INSERT_BEFORE, 5'd1, 32'h5555_aaaa));
        directed_rows.push_back(plain_row(OP_ADD_REAR, 5'd0, 32'haaaa_5555));
        directed_rows.push_back(plain_row(OP_ADD_FRONT, 5'd0, 32'h0001_0000));
        directed_rows.push_back(plain_row(OP_INSERT_BEFORE, 5'd10, 32'h0202_0202));
        directed_rows.push_back(plain_row(OP_ADD_REAR, 5'd0, 32'hfffe_fffe));
        directed_rows.push_back(known_row(OP_INSERT_BEFORE, 5'd16, 32'h4000_0001, ST_OK, 5'd16));
        // full store
        directed_rows.push_back(known_row(OP_ADD_FRONT, 5'd0, 32'h1111_1111, ST_FULL, 5'd16));
        directed_rows.push_back(known_row(OP_INSERT_BEFORE, 5'd17, '1, ST_FULL, 5'd16));
        directed_rows.push_back(known_row(OP_INSERT_BEFORE, 5'd18, '1, ST_RANGE, 5'd16));
        directed_rows.push_back(known_row(OPC_SPARE_7, 5'd31, '1, ST_OK, 5'd16));
        // edge positions of remove at
        directed_rows.push_back(plain_row(OP_REMOVE_AT, 5'd16, '0));
        directed_rows.push_back(plain_row(OP_REMOVE_AT, 5'd1, '0));
        directed_rows.push_back(known_row(OP_REMOVE_AT, 5'd0, '0, ST_RANGE, 5'd14));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.opcode, row.position, row.value, row.typed, row.expected);
        end

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            // swing between filling and draining so both ends get hit often
            if (model_len >= SEQ_CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
            else if (model_len == 0 && $urandom_range(2) == 0) grow = 1'b1;
            else if ($urandom_range(59) == 0) grow = ~grow;

            pick = $urandom_range(99);
            if (pick < 3) begin
                op = $urandom_range(1) ? OPC_SPARE_6 : OPC_SPARE_7;
            end else if ($urandom_range(99) < (grow ? 70 : 30)) begin
                case ($urandom_range(2))
                    0:       op = OP_ADD_FRONT;
                    1:       op = OP_ADD_REAR;
                    default: op = OP_INSERT_BEFORE;
                endcase
            end else begin
                case ($urandom_range(2))
                    0:       op = OP_REMOVE_FRONT;
                    1:       op = OP_REMOVE_REAR;
                    default: op = OP_REMOVE_AT;
                endcase
            end

            top = (op == OP_INSERT_BEFORE) ? model_len + 1 : model_len;
            case ($urandom_range(9))
                0:       pos = '0;
                1:       pos = POS_W'($urandom_range(31));
                2:       pos = POS_W'(top);
                default: pos = POS_W'($urandom_range(top > 0 ? top : 1, 1));
            endcase

            case ($urandom_range(9))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase

            send_request(op, pos, val, 1'b0, no_result);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("ran %0d requests (%0d directed), checked %0d results, deepest store %0d",
                 requests_sent, directed_rows.size(), results_checked, deepest_len);
        $display("statuses seen: ok %0d, underflow %0d, out of range %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_RANGE],
                 status_seen[ST_FULL]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> positional_sequence_store_unit.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_mem.sv
hw/rtl/positional_sequence_store_unit.sv
tb/sv/tb_positional_sequence_store_unit.sv
